>>> sv/msl_pkg.sv
// ---------------------------------------------------------------------------
// msl_pkg
// Shared types and constants for the midpoint subdivision line plotter.
// ---------------------------------------------------------------------------
package msl_pkg;

  localparam int CANVAS_SIDE = 64;
  localparam int STACK_DEPTH = 8;

  localparam int COORD_W     = 6;
  localparam int ACT_W       = 2;
  localparam int ROW_W       = $clog2(CANVAS_SIDE);
  localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W      = $clog2(STACK_DEPTH);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam logic [ACT_W-1:0] ACT_DRAW  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
  } seg_t;

  typedef struct packed {
    logic   wr;
    logic   clr;
    logic   rd;
    coord_t x;
    coord_t y;
  } canvas_cmd_t;

endpackage

>>> sv/msl_canvas.sv
// ---------------------------------------------------------------------------
// msl_canvas
// One-bit pixel canvas stored as rows, with a valid flag per row so that a
// clear needs no sweep. Single-pixel writes, registered single-pixel read.
// ---------------------------------------------------------------------------
module msl_canvas
  import msl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  canvas_cmd_t cmd,
  output logic        rd_bit
);

  logic [CANVAS_SIDE-1:0] mem [CANVAS_SIDE];
  logic [CANVAS_SIDE-1:0] row_vld_r;
  logic [CANVAS_SIDE-1:0] rd_row_r;
  logic [ROW_W-1:0]       rd_col_r;
  logic                   rd_ok_r;

  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] col;
  logic             in_range;

  assign row      = ROW_W'(cmd.x);
  assign col      = ROW_W'(cmd.y);
  assign in_range = (int'(cmd.x) < CANVAS_SIDE) && (int'(cmd.y) < CANVAS_SIDE);

  // stale rows are overwritten whole on first write
  always_ff @(posedge clk) begin
    if (cmd.wr && in_range) begin
      for (int i = 0; i < CANVAS_SIDE; i++) begin
        if (i == int'(col) || !row_vld_r[row]) begin
          mem[row][i] <= (i == int'(col));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.clr) begin
      row_vld_r <= '0;
    end else if (cmd.wr && in_range) begin
      row_vld_r[row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_row_r <= mem[row];
      rd_col_r <= col;
      rd_ok_r  <= in_range && row_vld_r[row];
    end
  end

  assign rd_bit = rd_ok_r & rd_row_r[rd_col_r];

endmodule

>>> sv/msl_seg_unit.sv
// ---------------------------------------------------------------------------
// msl_seg_unit
// Shared segment unit: leaf test (ends within one step per axis) and the
// truncated midpoint of the current segment.
// ---------------------------------------------------------------------------
module msl_seg_unit
  import msl_pkg::*;
(
  input  seg_t   seg,
  output logic   leaf,
  output coord_t mid_x,
  output coord_t mid_y
);

  logic [COORD_W:0] dx;
  logic [COORD_W:0] dy;
  logic [COORD_W:0] sx;
  logic [COORD_W:0] sy;
  logic             near_x;
  logic             near_y;

  assign dx = {1'b0, seg.xa} - {1'b0, seg.xb};
  assign dy = {1'b0, seg.ya} - {1'b0, seg.yb};
  assign sx = {1'b0, seg.xa} + {1'b0, seg.xb};
  assign sy = {1'b0, seg.ya} + {1'b0, seg.yb};

  // difference of -1, 0 or +1
  assign near_x = (dx == '0) || (dx == (COORD_W+1)'(1)) || (dx == '1);
  assign near_y = (dy == '0) || (dy == (COORD_W+1)'(1)) || (dy == '1);

  assign leaf  = near_x && near_y;
  assign mid_x = sx[COORD_W:1];
  assign mid_y = sy[COORD_W:1];

endmodule

>>> sv/midpoint_subdivision_line_plotter.sv
// ---------------------------------------------------------------------------
// midpoint_subdivision_line_plotter
// Draws lines on a one-bit canvas by midpoint subdivision with an explicit
// segment stack; also reads single pixels and clears the canvas.
//
//   channel | dir | tdata (low bit up)            | tuser
//   in_     | in  | x_first y_first x_second y_second | action
//   out_    | out | pixel_filled, zero pad         | done_action
//
// Draw: accept, split segments until a leaf, then write each leaf's two end
// pixels one after the other through the single canvas write port; finally
// load the result register. Read: registered canvas read. Clear or unused code
// goes straight to the result. Reset and clear drop per-row valid flags; no sweep.
// A new beat is taken while a finished result waits on a stalled out_tready.
// ---------------------------------------------------------------------------
module midpoint_subdivision_line_plotter
  import msl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // x_first, y_first, x_second, y_second
  input  logic [ACT_W-1:0]       in_tuser,   // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pixel_filled, 7 zero bits
  output logic [ACT_W-1:0]       out_tuser   // done_action
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_MARKB = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  seg_t             cur_r, cur_nxt;
  logic [TOP_W-1:0] top_r, top_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic             pix_r, pix_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [ACT_W-1:0] out_act_r, out_act_nxt;
  logic             out_pix_r, out_pix_nxt;
  seg_t             stack_r [STACK_DEPTH];

  seg_t             in_seg;
  logic             in_beat;
  logic             leaf;
  coord_t           mid_x;
  coord_t           mid_y;
  logic             push;
  logic [TOP_W-1:0] top_dec;
  logic             out_free;
  canvas_cmd_t      ccmd;
  logic             rd_bit;

  assign in_seg.xa = in_tdata[5:0];
  assign in_seg.ya = in_tdata[11:6];
  assign in_seg.xb = in_tdata[17:12];
  assign in_seg.yb = in_tdata[23:18];

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign top_dec   = top_r - TOP_W'(1);
  assign push      = (state_r == S_WALK) && !leaf && (top_r < TOP_W'(STACK_DEPTH));

  msl_seg_unit u_seg (
    .seg   (cur_r),
    .leaf  (leaf),
    .mid_x (mid_x),
    .mid_y (mid_y)
  );

  msl_canvas u_canvas (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (ccmd),
    .rd_bit (rd_bit)
  );

  always_comb begin
    ccmd     = '0;
    ccmd.x   = cur_r.xa;
    ccmd.y   = cur_r.ya;
    unique case (state_r)
      S_IDLE: begin
        ccmd.x   = in_seg.xa;
        ccmd.y   = in_seg.ya;
        ccmd.rd  = in_beat && (in_tuser == ACT_READ);
        ccmd.clr = in_beat && (in_tuser == ACT_CLEAR);
      end
      S_WALK: begin
        ccmd.wr = leaf;
      end
      S_MARKB: begin
        ccmd.wr = 1'b1;
        ccmd.x  = cur_r.xb;
        ccmd.y  = cur_r.yb;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    top_nxt     = top_r;
    act_nxt     = act_r;
    pix_nxt     = pix_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_act_nxt = out_act_r;
    out_pix_nxt = out_pix_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          act_nxt = in_tuser;
          pix_nxt = 1'b0;
          cur_nxt = in_seg;
          top_nxt = '0;
          priority case (in_tuser)
            ACT_DRAW: state_nxt = S_WALK;
            ACT_READ: state_nxt = S_RDATA;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (leaf) begin
          state_nxt = S_MARKB;
        end else begin
          cur_nxt.xb = mid_x;
          cur_nxt.yb = mid_y;
          if (push) begin
            top_nxt = top_r + TOP_W'(1);
          end
        end
      end
      S_MARKB: begin
        if (top_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = stack_r[top_dec[SIDX_W-1:0]];
          top_nxt   = top_dec;
          state_nxt = S_WALK;
        end
      end
      S_RDATA: begin
        pix_nxt   = rd_bit;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_act_nxt = act_r;
          out_pix_nxt = pix_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      top_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      top_r     <= top_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    act_r     <= act_nxt;
    pix_r     <= pix_nxt;
    out_act_r <= out_act_nxt;
    out_pix_r <= out_pix_nxt;
  end

  // pending second half: second point to midpoint
  always_ff @(posedge clk) begin
    if (push) begin
      stack_r[top_r[SIDX_W-1:0]] <= '{xa: cur_r.xb, ya: cur_r.yb, xb: mid_x, yb: mid_y};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = OUT_TDATA_W'(out_pix_r);

endmodule

>>> sv/msl_checker.sv
// ---------------------------------------------------------------------------
// msl_checker
// Port-level checks for the line plotter, bound to the top level.
// ---------------------------------------------------------------------------
module msl_checker
  import msl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [ACT_W-1:0]       out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on two cycles in a row");

  a_pix_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata != '0) |-> (out_tuser == ACT_READ) && (out_tdata[7:1] == '0))
    else $error("pixel bit set on a non-read result");

  a_reset_idle: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind midpoint_subdivision_line_plotter msl_checker u_msl_checker (.*);
